### rtl/srrw_pkg.sv
package srrw_pkg;

   localparam int MAX_WINDOW    = 63;
   localparam int SEQ_BITS      = 16;
   localparam int SLOT_W        = $clog2(MAX_WINDOW);
   localparam int MOD_W         = SEQ_BITS + 1;
   localparam int FIELD_W       = 16;
   localparam int TOTAL_W       = 32;
   localparam int WIN_W         = 6;
   localparam int CFG_MOD_W     = 17;
   localparam int CFG_W         = 17;
   localparam int CSR_IDX_W     = 1;
   localparam int RESET_WINDOW  = 30;
   localparam int RESET_MODULUS = 60000;
   localparam int MIN_MODULUS   = 64;
   localparam int MIN_MOD_BITS  = 6;
   localparam int MOD_LIMIT     = 1 << SEQ_BITS;
   localparam int RED_STEPS     = SEQ_BITS - MIN_MOD_BITS;
   localparam int RED_CNT_W     = $clog2(RED_STEPS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_MODULUS = 1'b1;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ACK,
      ST_READ,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic eval;
      logic fire_ack;
      logic fire_deliver;
   } cmd_type;

   typedef struct packed {
      logic cfg_busy;
      logic keep;
      logic more_after_ack;
      logic more_after_deliver;
      logic rsp_free;
   } status_type;

endpackage

### rtl/srrw_ram.sv
module srrw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/srrw_reduce.sv
module srrw_reduce import srrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SEQ_BITS-1:0] value,
   input  logic [MOD_W-1:0]    modulus,
   output logic                busy,
   output logic                done,
   output logic [SEQ_BITS-1:0] result
);

   logic [SEQ_BITS-1:0]  rem_ff, rem_in;
   logic [RED_STEPS-1:0] bits_ff, bits_in;
   logic [RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [MOD_W-1:0]     trial;
   logic [MOD_W-1:0]     trial_sub;

   // One restoring remainder step per cycle. The top bits of the value are
   // already below the smallest modulus and are loaded directly.
   always_comb begin
      trial     = {rem_ff, bits_ff[RED_STEPS-1]};
      trial_sub = (trial >= modulus) ? (trial - modulus) : trial;
   end

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = SEQ_BITS'(value >> RED_STEPS);
         bits_in = value[RED_STEPS-1:0];
         cnt_in  = RED_CNT_W'(RED_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = trial_sub[SEQ_BITS-1:0];
         bits_in = bits_ff << 1;
         cnt_in  = cnt_ff - RED_CNT_W'(1);
         if (cnt_ff == RED_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
   end

   assign busy   = busy_ff;
   assign done   = busy_ff && (cnt_ff == RED_CNT_W'(1));
   assign result = trial_sub[SEQ_BITS-1:0];

endmodule

### rtl/srrw_ctrl.sv
module srrw_ctrl import srrw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !status.cfg_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = status.keep ? ST_ACK : ST_IDLE;
         end
         ST_ACK: begin
            if (status.rsp_free) begin
               state_in = status.more_after_ack ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.rsp_free && !status.more_after_deliver) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready       = (state_ff == ST_IDLE) && !status.cfg_busy;
      cmd.latch_req    = req_tready && req_tvalid;
      cmd.eval         = (state_ff == ST_EVAL);
      cmd.fire_ack     = (state_ff == ST_ACK) && status.rsp_free;
      cmd.fire_deliver = (state_ff == ST_DELIVER) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/srrw_datapath.sv
module srrw_datapath import srrw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [FIELD_W-1:0]   req_seq_number,
   input  logic                 req_is_ack_packet,
   input  logic [FIELD_W-1:0]   req_payload_handle,
   input  logic [FIELD_W-1:0]   req_payload_length,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic                 rsp_result_kind,
   output logic [FIELD_W-1:0]   rsp_ack_seq,
   output logic [FIELD_W-1:0]   rsp_ack_window_head,
   output logic [FIELD_W-1:0]   rsp_deliver_handle,
   output logic [FIELD_W-1:0]   rsp_deliver_length,
   output logic [TOTAL_W-1:0]   rsp_bytes_total,
   output logic                 rsp_last_result
);

   // Configuration.
   logic [WIN_W-1:0]     window_size_ff, window_size_in;
   logic [CFG_MOD_W-1:0] seq_modulus_ff, seq_modulus_in;
   logic [CFG_MOD_W-1:0] mod_eff;
   logic [MOD_W-1:0]     mod_m;
   logic [WIN_W-1:0]     win_eff;

   // Window state.
   logic [SEQ_BITS-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]     head_slot_ff, head_slot_in;
   logic [MAX_WINDOW-1:0] flags_ff, flags_in;
   logic [TOTAL_W-1:0]    bytes_ff, bytes_in;

   // Request held for evaluation.
   logic [FIELD_W-1:0] seq_ff;
   logic               is_ack_ff;
   logic [FIELD_W-1:0] handle_ff;
   logic [FIELD_W-1:0] length_ff;
   logic [SLOT_W-1:0]  ahead_ff;
   logic               in_win_ff;
   logic [SEQ_BITS-1:0] head0_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff;
   logic [FIELD_W-1:0] out_seq_ff;
   logic [FIELD_W-1:0] out_head_ff;
   logic [FIELD_W-1:0] out_handle_ff;
   logic [FIELD_W-1:0] out_length_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic               out_last_ff;

   // Head reduction after a register write.
   logic                wr_pend_ff;
   logic                again_ff, again_in;
   logic                red_start;
   logic                red_busy;
   logic                red_done;
   logic [SEQ_BITS-1:0] red_result;

   logic [MOD_W-1:0]    seq_m;
   logic [MOD_W-1:0]    head_m;
   logic [MOD_W-1:0]    win_m;
   logic [MOD_W-1:0]    ahead;
   logic [MOD_W-1:0]    behind;
   logic                seq_ok;
   logic                in_win_now;
   logic                keep_now;
   logic [SLOT_W:0]     slot_sum;
   logic [SLOT_W-1:0]   wr_slot;
   logic [SLOT_W-1:0]   next_slot;
   logic [MOD_W-1:0]    head_inc;
   logic [2*FIELD_W-1:0] rd_data;
   logic [FIELD_W-1:0]  rd_handle;
   logic [FIELD_W-1:0]  rd_length;
   logic [TOTAL_W-1:0]  bytes_add;

   always_comb begin
      if (seq_modulus_ff < CFG_MOD_W'(MIN_MODULUS)) begin
         mod_eff = CFG_MOD_W'(MIN_MODULUS);
      end else if (seq_modulus_ff > CFG_MOD_W'(MOD_LIMIT)) begin
         mod_eff = CFG_MOD_W'(MOD_LIMIT);
      end else begin
         mod_eff = seq_modulus_ff;
      end
      mod_m = MOD_W'(mod_eff);

      if (window_size_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (window_size_ff > WIN_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = window_size_ff;
      end
   end

   // Distance of the sequence number ahead of and behind the head.
   always_comb begin
      seq_m  = MOD_W'(seq_ff);
      head_m = MOD_W'(head_ff);
      win_m  = MOD_W'(win_eff);
      seq_ok = !is_ack_ff && (CFG_MOD_W'(seq_ff) < mod_eff);
      ahead  = (seq_m >= head_m) ? (seq_m - head_m) : (seq_m + mod_m - head_m);
      behind = (head_m >= seq_m) ? (head_m - seq_m) : (head_m + mod_m - seq_m);
      in_win_now = seq_ok && (ahead < win_m);
      keep_now   = in_win_now ||
                   (seq_ok && (behind != '0) && (behind <= win_m));
   end

   always_comb begin
      slot_sum = (SLOT_W+1)'(head_slot_ff) + (SLOT_W+1)'(ahead_ff);
      if (slot_sum >= (SLOT_W+1)'(MAX_WINDOW)) begin
         slot_sum = slot_sum - (SLOT_W+1)'(MAX_WINDOW);
      end
      wr_slot   = slot_sum[SLOT_W-1:0];
      next_slot = (head_slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                             : head_slot_ff + SLOT_W'(1);
      head_inc  = head_m + MOD_W'(1);
      if (head_inc == mod_m) begin
         head_inc = '0;
      end
      rd_handle = rd_data[2*FIELD_W-1:FIELD_W];
      rd_length = rd_data[FIELD_W-1:0];
      bytes_add = bytes_ff + TOTAL_W'(rd_length);
   end

   always_comb begin
      status.keep               = keep_now;
      status.rsp_free           = !rsp_valid_ff || rsp_tready;
      status.more_after_ack     = in_win_ff && ((ahead_ff == '0) || flags_ff[head_slot_ff]);
      status.more_after_deliver = flags_ff[next_slot];
      status.cfg_busy           = red_busy || wr_pend_ff || again_ff;
   end

   // Register writes.
   always_comb begin
      window_size_in = window_size_ff;
      seq_modulus_in = seq_modulus_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_in = csr_wdata[WIN_W-1:0];
            CSR_SEQ_MODULUS: seq_modulus_in = csr_wdata[CFG_MOD_W-1:0];
            default:         window_size_in = window_size_ff;
         endcase
      end
   end

   // A write that lands while a reduction runs is served by one more pass.
   always_comb begin
      red_start = (wr_pend_ff || again_ff) && !red_busy;
      again_in  = again_ff;
      if (red_start) begin
         again_in = 1'b0;
      end else if (wr_pend_ff && red_busy) begin
         again_in = 1'b1;
      end
   end

   always_comb begin
      head_in      = head_ff;
      head_slot_in = head_slot_ff;
      flags_in     = flags_ff;
      bytes_in     = bytes_ff;
      if (red_done) begin
         head_in = red_result;
      end else if (cmd.fire_deliver) begin
         head_in = head_inc[SEQ_BITS-1:0];
      end
      if (cmd.fire_ack && in_win_ff) begin
         flags_in[wr_slot] = 1'b1;
      end
      if (cmd.fire_deliver) begin
         flags_in[head_slot_ff] = 1'b0;
         head_slot_in           = next_slot;
         bytes_in               = bytes_add;
      end
      if (csr_we) begin
         flags_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fire_ack || cmd.fire_deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WIN_W'(RESET_WINDOW);
         seq_modulus_ff <= CFG_MOD_W'(RESET_MODULUS);
         head_ff        <= '0;
         head_slot_ff   <= '0;
         flags_ff       <= '0;
         bytes_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         wr_pend_ff     <= 1'b0;
         again_ff       <= 1'b0;
         in_win_ff      <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         seq_modulus_ff <= seq_modulus_in;
         head_ff        <= head_in;
         head_slot_ff   <= head_slot_in;
         flags_ff       <= flags_in;
         bytes_ff       <= bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
         wr_pend_ff     <= csr_we;
         again_ff       <= again_in;
         if (cmd.eval) begin
            in_win_ff <= in_win_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         seq_ff    <= req_seq_number;
         is_ack_ff <= req_is_ack_packet;
         handle_ff <= req_payload_handle;
         length_ff <= req_payload_length;
      end
      if (cmd.eval) begin
         ahead_ff <= ahead[SLOT_W-1:0];
         head0_ff <= head_ff;
      end
      if (cmd.fire_ack) begin
         kind_ff       <= KIND_ACK;
         out_seq_ff    <= seq_ff;
         out_head_ff   <= FIELD_W'(head_ff);
         out_handle_ff <= '0;
         out_length_ff <= '0;
         out_total_ff  <= bytes_ff;
         out_last_ff   <= !status.more_after_ack;
      end else if (cmd.fire_deliver) begin
         kind_ff       <= KIND_DELIVER;
         out_seq_ff    <= FIELD_W'(head_ff);
         out_head_ff   <= FIELD_W'(head0_ff);
         out_handle_ff <= rd_handle;
         out_length_ff <= rd_length;
         out_total_ff  <= bytes_add;
         out_last_ff   <= !status.more_after_deliver;
      end
   end

   // The read address follows the next slot pointer so that the data of the
   // new head slot is ready in the cycle after a delivery.
   srrw_ram #(
      .WIDTH (2 * FIELD_W),
      .DEPTH (MAX_WINDOW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.fire_ack && in_win_ff),
      .wr_addr (wr_slot),
      .wr_data ({handle_ff, length_ff}),
      .rd_addr (head_slot_in),
      .rd_data (rd_data)
   );

   srrw_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .value   (head_ff),
      .modulus (mod_m),
      .busy    (red_busy),
      .done    (red_done),
      .result  (red_result)
   );

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_ack_seq         = out_seq_ff;
   assign rsp_ack_window_head = out_head_ff;
   assign rsp_deliver_handle  = out_handle_ff;
   assign rsp_deliver_length  = out_length_ff;
   assign rsp_bytes_total     = out_total_ff;
   assign rsp_last_result     = out_last_ff;

endmodule

### rtl/selective_repeat_receive_window.sv
// An accepted request is evaluated; if it is kept, it passes the ack state and its ack
// leaves the result register. In-order deliveries follow through the read and deliver states,
// then one per cycle while taken. A dropped request returns to idle after evaluation,
// and new requests are taken only in idle, once the drain of the slot RAM has ended.
// Reset is synchronous: head, slot pointer, received flags and byte total clear.
// A register write holds off requests while the head is reduced.
module selective_repeat_receive_window import srrw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,  // seq_number, payload_handle, payload_length
   input  logic                 req_tuser,  // is_ack_packet
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,  // ack_seq, ack_window_head, deliver_handle,
                                            // deliver_length, bytes_total
   output logic                 rsp_tuser,  // result_kind
   output logic                 rsp_tlast,  // last_result
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   logic [FIELD_W-1:0] ack_seq;
   logic [FIELD_W-1:0] ack_window_head;
   logic [FIELD_W-1:0] deliver_handle;
   logic [FIELD_W-1:0] deliver_length;
   logic [TOTAL_W-1:0] bytes_total;

   srrw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srrw_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_seq_number      (req_tdata[15:0]),
      .req_is_ack_packet   (req_tuser),
      .req_payload_handle  (req_tdata[31:16]),
      .req_payload_length  (req_tdata[47:32]),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_result_kind     (rsp_tuser),
      .rsp_ack_seq         (ack_seq),
      .rsp_ack_window_head (ack_window_head),
      .rsp_deliver_handle  (deliver_handle),
      .rsp_deliver_length  (deliver_length),
      .rsp_bytes_total     (bytes_total),
      .rsp_last_result     (rsp_tlast)
   );

   assign rsp_tdata = {bytes_total, deliver_length, deliver_handle, ack_window_head, ack_seq};

endmodule
